>>> design/rsa_pkg.sv
// shared types, constants and widths for the rgb saturation adjust block
package rsa_pkg;

   // channel format
   localparam int FRACTION_BITS = 15;
   localparam int CHAN_W = 16;
   localparam logic [31:0] ONE_VAL = 32'd1 << FRACTION_BITS;
   localparam logic [CHAN_W-1:0] CLAMP_MAX =
      (ONE_VAL > 32'h0000_FFFF) ? {CHAN_W{1'b1}} : ONE_VAL[CHAN_W-1:0];

   // gain register, unsigned q2.8
   localparam int GAIN_W = 10;
   localparam int GAIN_FRAC = 8;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd384;

   // luminance weights, 16-bit fractions summing to 65536
   localparam int WEIGHT_W = 16;
   localparam logic [WEIGHT_W-1:0] WEIGHT_R = 16'd19595;
   localparam logic [WEIGHT_W-1:0] WEIGHT_G = 16'd38470;
   localparam logic [WEIGHT_W-1:0] WEIGHT_B = 16'd7471;

   // square and weighted square widths
   localparam int SQR_W = 2 * CHAN_W;
   localparam int WSQ_W = SQR_W + WEIGHT_W;

   // square root: radicand, root and partial remainder widths
   localparam int RAD_W = WSQ_W - WEIGHT_W;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W = ROOT_W + 1;

   // gain product width
   localparam int PROD_W = CHAN_W + 1 + GAIN_W;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // word handed from one square root cell to the next
   typedef struct packed {
      pixel_type pix;
      logic [RAD_W-1:0] rad;
      logic [REM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } root_word_type;

endpackage

>>> design/rsa_if.sv
// valid/ready channel interfaces for pixel, result and gain register words

interface rsa_req_if;
   logic valid;
   logic ready;
   logic [rsa_pkg::CHAN_W-1:0] red_in;
   logic [rsa_pkg::CHAN_W-1:0] green_in;
   logic [rsa_pkg::CHAN_W-1:0] blue_in;

   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rsa_rsp_if;
   logic valid;
   logic ready;
   logic [rsa_pkg::CHAN_W-1:0] red_out;
   logic [rsa_pkg::CHAN_W-1:0] green_out;
   logic [rsa_pkg::CHAN_W-1:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface rsa_csr_if;
   logic valid;
   logic ready;
   logic [rsa_pkg::GAIN_W-1:0] saturation_gain;

   modport source (output valid, saturation_gain, input ready);
   modport sink (input valid, saturation_gain, output ready);
endinterface

>>> design/rsa_luma_front.sv
// squares, weights and sums the channels into the square root radicand
module rsa_luma_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  rsa_pkg::pixel_type      in_pix,
   output logic                    out_valid,
   output rsa_pkg::root_word_type  out_word
);

   logic [2:0] valid_ff;
   rsa_pkg::pixel_type pix1_ff, pix2_ff, pix3_ff;
   logic [rsa_pkg::SQR_W-1:0] sq_r_ff, sq_g_ff, sq_b_ff;
   logic [rsa_pkg::WSQ_W-1:0] wsq_r_ff, wsq_g_ff, wsq_b_ff;
   logic [rsa_pkg::WSQ_W-1:0] sum_ff, sum_in;

   // weighted squares never carry out of the sum since the weights add to one
   assign sum_in = wsq_r_ff + wsq_g_ff + wsq_b_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // square, weight, sum
   always_ff @(posedge clock) begin
      if (en) begin
         pix1_ff <= in_pix;
         sq_r_ff <= rsa_pkg::SQR_W'(in_pix.red * in_pix.red);
         sq_g_ff <= rsa_pkg::SQR_W'(in_pix.green * in_pix.green);
         sq_b_ff <= rsa_pkg::SQR_W'(in_pix.blue * in_pix.blue);
         pix2_ff <= pix1_ff;
         wsq_r_ff <= rsa_pkg::WSQ_W'(sq_r_ff * rsa_pkg::WEIGHT_R);
         wsq_g_ff <= rsa_pkg::WSQ_W'(sq_g_ff * rsa_pkg::WEIGHT_G);
         wsq_b_ff <= rsa_pkg::WSQ_W'(sq_b_ff * rsa_pkg::WEIGHT_B);
         pix3_ff <= pix2_ff;
         sum_ff <= sum_in;
      end
   end

   // seed word for the first square root cell
   assign out_valid = valid_ff[2];
   always_comb begin
      out_word.pix = pix3_ff;
      out_word.rad = sum_ff[rsa_pkg::WSQ_W-1:rsa_pkg::WEIGHT_W];
      out_word.rem = '0;
      out_word.root = '0;
   end

endmodule

>>> design/rsa_sqrt_cell.sv
// one restoring square root cell, resolves one root bit per word
module rsa_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  rsa_pkg::root_word_type  in_word,
   output logic                    out_valid,
   output rsa_pkg::root_word_type  out_word
);

   logic valid_ff;
   rsa_pkg::root_word_type word_ff, word_in;
   logic [rsa_pkg::REM_W+1:0] rem_sh;
   logic [rsa_pkg::REM_W+1:0] trial;

   // bring down the next radicand digit pair and try a one bit
   always_comb begin
      rem_sh = {in_word.rem, in_word.rad[rsa_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, in_word.root, 2'b01};
      word_in.pix = in_word.pix;
      word_in.rad = {in_word.rad[rsa_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         word_in.rem = rsa_pkg::REM_W'(rem_sh - trial);
         word_in.root = {in_word.root[rsa_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         word_in.rem = rsa_pkg::REM_W'(rem_sh);
         word_in.root = {in_word.root[rsa_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word = word_ff;

endmodule

>>> design/rsa_chan_adjust.sv
// scales each channel's distance from the brightness by the gain and clamps
module rsa_chan_adjust (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  rsa_pkg::pixel_type          in_pix,
   input  logic [rsa_pkg::ROOT_W-1:0]  in_root,
   input  logic [rsa_pkg::GAIN_W-1:0]  gain,
   output logic                        out_valid,
   output rsa_pkg::pixel_type          out_pix
);

   localparam int V_W = rsa_pkg::PROD_W + 1;

   logic valid_ff;
   logic [rsa_pkg::ROOT_W-1:0] root_ff;
   logic signed [rsa_pkg::PROD_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;

   // (c - p) * gain, signed
   function automatic logic signed [rsa_pkg::PROD_W-1:0] scale_diff(
      input logic [rsa_pkg::CHAN_W-1:0] c,
      input logic [rsa_pkg::ROOT_W-1:0] p,
      input logic [rsa_pkg::GAIN_W-1:0] g
   );
      logic signed [rsa_pkg::PROD_W-1:0] diff;
      logic signed [rsa_pkg::PROD_W-1:0] gs;
      diff = $signed(rsa_pkg::PROD_W'(c)) - $signed(rsa_pkg::PROD_W'(p));
      gs = $signed(rsa_pkg::PROD_W'(g));
      return rsa_pkg::PROD_W'(diff * gs);
   endfunction

   // p + floor(prod / 256), saturated to 0 .. one
   function automatic logic [rsa_pkg::CHAN_W-1:0] finish_chan(
      input logic signed [rsa_pkg::PROD_W-1:0] prod,
      input logic [rsa_pkg::ROOT_W-1:0] p
   );
      logic signed [V_W-1:0] v;
      logic signed [V_W+32:0] v_ext;
      logic signed [V_W+32:0] one_ext;
      v = $signed(V_W'(p)) + V_W'(prod >>> rsa_pkg::GAIN_FRAC);
      v_ext = (V_W+33)'(v);
      one_ext = $signed((V_W+33)'(rsa_pkg::ONE_VAL));
      if (v < 0) begin
         return '0;
      end else if (v_ext > one_ext) begin
         return rsa_pkg::ONE_VAL[rsa_pkg::CHAN_W-1:0];
      end else begin
         return v[rsa_pkg::CHAN_W-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   // gain products
   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= in_root;
         prod_r_ff <= scale_diff(in_pix.red, in_root, gain);
         prod_g_ff <= scale_diff(in_pix.green, in_root, gain);
         prod_b_ff <= scale_diff(in_pix.blue, in_root, gain);
      end
   end

   // floor, offset and clamp feed the output register
   assign out_valid = valid_ff;
   always_comb begin
      out_pix.red = finish_chan(prod_r_ff, root_ff);
      out_pix.green = finish_chan(prod_g_ff, root_ff);
      out_pix.blue = finish_chan(prod_b_ff, root_ff);
   end

endmodule

>>> design/rgb_saturation_adjust.sv
// top level: saturation adjust of one rgb pixel per word
// Returns one adjusted pixel word for each accepted pixel word, in order. The square,
// weighted square and sum registers come first, a row of 16 square root cells resolves
// one brightness bit each, the gain product register follows and the output register
// is last. Sustained rate is one word per clock while rsp_chan.ready stays high; a skid
// register behind the output register holds one word while the response side stalls,
// and req_chan.ready drops only once that skid register is full. The gain register
// resets to 1.5 (384) and is written through csr_chan, which is always ready; the user
// must write it only while no words are in flight, which the block does not enforce.
module rgb_saturation_adjust (
   input  logic       clock,
   input  logic       reset,
   rsa_req_if.sink    req_chan,
   rsa_rsp_if.source  rsp_chan,
   rsa_csr_if.sink    csr_chan
);

   logic en;
   logic [rsa_pkg::GAIN_W-1:0] gain_ff;
   rsa_pkg::pixel_type req_pix;
   logic cell_valid [rsa_pkg::ROOT_W+1];
   rsa_pkg::root_word_type cell_word [rsa_pkg::ROOT_W+1];
   logic adj_valid;
   rsa_pkg::pixel_type adj_pix;
   logic take;
   logic out_free;
   logic out_valid_ff;
   rsa_pkg::pixel_type out_pix_ff;
   logic skid_full_ff;
   rsa_pkg::pixel_type skid_pix_ff;

   // gain register
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= rsa_pkg::GAIN_RESET;
      end else if (csr_chan.valid) begin
         gain_ff <= csr_chan.saturation_gain;
      end
   end

   // whole pipeline moves unless the skid register is occupied
   assign en = !skid_full_ff;
   assign req_chan.ready = en;

   always_comb begin
      req_pix.red = req_chan.red_in;
      req_pix.green = req_chan.green_in;
      req_pix.blue = req_chan.blue_in;
   end

   // weighted square sum
   rsa_luma_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_pix    (req_pix),
      .out_valid (cell_valid[0]),
      .out_word  (cell_word[0])
   );

   // square root cell row
   for (genvar i = 0; i < rsa_pkg::ROOT_W; i++) begin : g_cell
      rsa_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cell_valid[i]),
         .in_word   (cell_word[i]),
         .out_valid (cell_valid[i+1]),
         .out_word  (cell_word[i+1])
      );
   end

   // gain and clamp
   rsa_chan_adjust u_adjust (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cell_valid[rsa_pkg::ROOT_W]),
      .in_pix    (cell_word[rsa_pkg::ROOT_W].pix),
      .in_root   (cell_word[rsa_pkg::ROOT_W].root),
      .gain      (gain_ff),
      .out_valid (adj_valid),
      .out_pix   (adj_pix)
   );

   // output register with skid register behind it
   assign take = en && adj_valid;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_full_ff) begin
            out_valid_ff <= 1'b1;
            skid_full_ff <= 1'b0;
         end else begin
            out_valid_ff <= take;
         end
      end else if (take) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_full_ff) begin
            out_pix_ff <= skid_pix_ff;
         end else if (take) begin
            out_pix_ff <= adj_pix;
         end
      end else if (take) begin
         skid_pix_ff <= adj_pix;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.red_out = out_pix_ff.red;
   assign rsp_chan.green_out = out_pix_ff.green;
   assign rsp_chan.blue_out = out_pix_ff.blue;

endmodule

>>> design/rsa_checker.sv
// port level checks for the saturation adjust block and their bind
module rsa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rsa_pkg::CHAN_W-1:0]  rsp_red,
   input logic [rsa_pkg::CHAN_W-1:0]  rsp_green,
   input logic [rsa_pkg::CHAN_W-1:0]  rsp_blue
);

   // no response word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue))
      else $error("stalled response word changed");

   // request side backs up only after the response side stalled
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("request ready dropped without a response stall");

   // every channel is clamped to one
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red <= rsa_pkg::CLAMP_MAX && rsp_green <= rsa_pkg::CLAMP_MAX
         && rsp_blue <= rsa_pkg::CLAMP_MAX)
      else $error("response channel above one");

endmodule

bind rgb_saturation_adjust rsa_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_red   (rsp_chan.red_out),
   .rsp_green (rsp_chan.green_out),
   .rsp_blue  (rsp_chan.blue_out)
);
